[rtl/rpc_rhp_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_rhp_pkg
// Shared types and constants of the record-marked rpc header parser.
// ----------------------------------------------------------------------------
package rpc_rhp_pkg;

   localparam int ByteWidth      = 8;
   localparam int WordWidth      = 32;
   localparam int CsrIndexWidth  = 1;
   localparam int RspFieldsWidth = 4 + 8 * WordWidth + 1;
   localparam int RspDataWidth   = ((RspFieldsWidth + 7) / 8) * 8;

   localparam logic [CsrIndexWidth-1:0] CsrWatchedProgram = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrWatchedVersion = 1'd1;

   localparam logic [WordWidth-1:0] WatchedProgramReset = 32'd100003;
   localparam logic [WordWidth-1:0] WatchedVersionReset = 32'd3;
   localparam logic [WordWidth-1:0] RpcVersionTwo       = 32'd2;
   localparam logic [WordWidth-1:0] MsgTypeCall         = 32'd0;
   localparam logic [WordWidth-1:0] MsgTypeReply        = 32'd1;

   typedef enum logic [3:0] {
      StatusCallOk       = 4'd0,
      StatusReplyOk      = 4'd1,
      StatusShortHeader  = 4'd2,
      StatusCallTrunc    = 4'd3,
      StatusBadRpcVer    = 4'd4,
      StatusReplyTrunc   = 4'd5,
      StatusDenied       = 4'd6,
      StatusAcceptFail   = 4'd7,
      StatusOtherType    = 4'd8
   } status_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [WordWidth-1:0] message_length;
      logic [WordWidth-1:0] accept_status;
      logic [WordWidth-1:0] reply_status;
      logic                 is_watched;
      logic [WordWidth-1:0] procedure;
      logic [WordWidth-1:0] prog_version;
      logic [WordWidth-1:0] program_res;
      logic [WordWidth-1:0] message_type;
      logic [WordWidth-1:0] xid;
      status_type           status;
   } rsp_type;

endpackage

[rtl/rpc_record_header_parser.sv]
// ----------------------------------------------------------------------------
// rpc_record_header_parser
// Parses the header of record-marked rpc messages from a byte stream and
// gives one summary per message.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock unless the parser stalls. A byte is held
// in an input register, from which the fragment-mark, word-assembly and header
// logic updates the parser state; the summary of a message lands in the
// result register at the edge where its final byte leaves the input register.
// The only stall happens when the byte that ends a message meets a full
// result register that is not being taken; otherwise the input keeps
// running at one byte per cycle while a summary waits. The watched
// program and version registers should be written only while no message
// is in flight.
module rpc_record_header_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rpc_rhp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rpc_rhp_pkg::WordWidth-1:0]     csr_data,
   // stream bytes
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rpc_rhp_pkg::ByteWidth-1:0]     req_tdata,    // stream_byte
   // message summaries
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status[3:0], xid[35:4], message_type[67:36], program_res[99:68],
   // prog_version[131:100], procedure[163:132], is_watched[164],
   // reply_status[196:165], accept_status[228:197], message_length[260:229]
   output logic [rpc_rhp_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import rpc_rhp_pkg::*;

   typedef enum logic [4:0] {
      StXid        = 5'd0,
      StType       = 5'd1,
      StRpcver     = 5'd2,
      StProg       = 5'd3,
      StVers       = 5'd4,
      StProc       = 5'd5,
      StCredFlav   = 5'd6,
      StCredLen    = 5'd7,
      StCredSkip   = 5'd8,
      StVerfFlav   = 5'd9,
      StVerfLen    = 5'd10,
      StVerfSkip   = 5'd11,
      StCallDone   = 5'd12,
      StRstat      = 5'd13,
      StAuthFlav   = 5'd14,
      StAuthLen    = 5'd15,
      StAuthSkip   = 5'd16,
      StAstat      = 5'd17,
      StReplyDone  = 5'd18,
      StOther      = 5'd19
   } step_type;

   localparam logic [2:0] MarkDone = 3'd4;
   localparam logic [2:0] MarkLast = 3'd3;

   // configuration
   logic [WordWidth-1:0] watched_prog_ff, watched_vers_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;

   // parser state
   logic [23:0]          mark_shift_ff, mark_shift_in;
   logic [2:0]           mark_count_ff, mark_count_in;
   logic [30:0]          frag_rem_ff, frag_rem_in;
   logic                 last_ff, last_in;
   step_type             step_ff, step_in;
   logic [23:0]          acc_ff, acc_in;
   logic [1:0]           word_count_ff, word_count_in;
   logic [WordWidth-1:0] skip_ff, skip_in;
   logic [WordWidth-1:0] xid_ff, xid_in;
   logic [WordWidth-1:0] type_ff, type_in;
   logic                 rpcver_ok_ff, rpcver_ok_in;
   logic [WordWidth-1:0] prog_ff, prog_in;
   logic [WordWidth-1:0] vers_ff, vers_in;
   logic [WordWidth-1:0] proc_ff, proc_in;
   logic [WordWidth-1:0] rstat_ff, rstat_in;
   logic [WordWidth-1:0] astat_ff, astat_in;
   logic [WordWidth-1:0] len_ff, len_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, summary;

   logic                 proc_go, emit, frag_end, is_call, is_reply;
   logic [WordWidth-1:0] mark_word, word;
   logic [WordWidth:0]   len_sum;
   status_type           verdict;

   assign csr_ready  = 1'b1;
   assign proc_go    = in_valid_ff && (!emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_go;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - RspFieldsWidth){1'b0}}, out_ff};

   always_comb begin
      mark_shift_in = mark_shift_ff;
      mark_count_in = mark_count_ff;
      frag_rem_in   = frag_rem_ff;
      last_in       = last_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      word_count_in = word_count_ff;
      skip_in       = skip_ff;
      xid_in        = xid_ff;
      type_in       = type_ff;
      rpcver_ok_in  = rpcver_ok_ff;
      prog_in       = prog_ff;
      vers_in       = vers_ff;
      proc_in       = proc_ff;
      rstat_in      = rstat_ff;
      astat_in      = astat_ff;
      len_in        = len_ff;
      frag_end      = 1'b0;
      emit          = 1'b0;
      mark_word     = {mark_shift_ff, in_byte_ff};
      word          = {acc_ff, in_byte_ff};
      len_sum       = {1'b0, len_ff} + {2'b00, mark_word[30:0]};

      if (mark_count_ff != MarkDone) begin
         mark_shift_in = mark_word[23:0];
         mark_count_in = mark_count_ff + 3'd1;
         if (mark_count_ff == MarkLast) begin
            last_in       = mark_word[31];
            frag_rem_in   = mark_word[30:0];
            len_in        = len_sum[WordWidth] ? '1 : len_sum[WordWidth-1:0];
            mark_shift_in = '0;
            frag_end      = (mark_word[30:0] == '0);
         end
      end else begin
         unique case (step_ff) inside
            StCredSkip, StVerfSkip, StAuthSkip: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 32'd1;
               end
               if (skip_in == '0) begin
                  step_in = (step_ff == StCredSkip) ? StVerfFlav :
                            (step_ff == StVerfSkip) ? StCallDone : StAstat;
               end
            end
            StCallDone, StReplyDone, StOther: begin
            end
            default: begin
               if (word_count_ff == 2'd3) begin
                  word_count_in = 2'd0;
                  acc_in        = '0;
                  unique case (step_ff)
                     StXid: begin
                        xid_in  = word;
                        step_in = StType;
                     end
                     StType: begin
                        type_in = word;
                        step_in = (word == MsgTypeCall)  ? StRpcver :
                                  (word == MsgTypeReply) ? StRstat : StOther;
                     end
                     StRpcver: begin
                        rpcver_ok_in = (word == RpcVersionTwo);
                        step_in      = StProg;
                     end
                     StProg: begin
                        prog_in = word;
                        step_in = StVers;
                     end
                     StVers: begin
                        vers_in = word;
                        step_in = StProc;
                     end
                     StProc: begin
                        proc_in = word;
                        step_in = StCredFlav;
                     end
                     StCredFlav: step_in = StCredLen;
                     StCredLen: begin
                        skip_in = word;
                        step_in = (word != '0) ? StCredSkip : StVerfFlav;
                     end
                     StVerfFlav: step_in = StVerfLen;
                     StVerfLen: begin
                        skip_in = word;
                        step_in = (word != '0) ? StVerfSkip : StCallDone;
                     end
                     StRstat: begin
                        rstat_in = word;
                        step_in  = StAuthFlav;
                     end
                     StAuthFlav: step_in = StAuthLen;
                     StAuthLen: begin
                        skip_in = word;
                        step_in = (word != '0) ? StAuthSkip : StAstat;
                     end
                     StAstat: begin
                        astat_in = word;
                        step_in  = StReplyDone;
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  acc_in        = word[23:0];
                  word_count_in = word_count_ff + 2'd1;
               end
            end
         endcase
         if (frag_rem_ff != '0) begin
            frag_rem_in = frag_rem_ff - 31'd1;
         end
         frag_end = (frag_rem_in == '0);
      end

      // summary from the state after this byte
      is_call  = (step_in >= StRpcver) && (step_in <= StCallDone);
      is_reply = (step_in >= StRstat) && (step_in <= StReplyDone);
      if (step_in <= StType) begin
         verdict = StatusShortHeader;
      end else if (is_call) begin
         verdict = (step_in != StCallDone) ? StatusCallTrunc :
                   !rpcver_ok_in           ? StatusBadRpcVer : StatusCallOk;
      end else if (is_reply) begin
         verdict = (step_in != StReplyDone) ? StatusReplyTrunc :
                   (rstat_in != '0)         ? StatusDenied     :
                   (astat_in != '0)         ? StatusAcceptFail : StatusReplyOk;
      end else begin
         verdict = StatusOtherType;
      end
      summary.status         = verdict;
      summary.xid            = xid_in;
      summary.message_type   = type_in;
      summary.program_res    = is_call ? prog_in : '0;
      summary.prog_version   = is_call ? vers_in : '0;
      summary.procedure      = is_call ? proc_in : '0;
      summary.is_watched     = (verdict == StatusCallOk) && (prog_in == watched_prog_ff) &&
                               (vers_in == watched_vers_ff);
      summary.reply_status   = is_reply ? rstat_in : '0;
      summary.accept_status  = is_reply ? astat_in : '0;
      summary.message_length = len_in;

      if (frag_end && last_in) begin
         emit          = 1'b1;
         mark_shift_in = '0;
         mark_count_in = '0;
         frag_rem_in   = '0;
         last_in       = 1'b0;
         step_in       = StXid;
         acc_in        = '0;
         word_count_in = '0;
         skip_in       = '0;
         xid_in        = '0;
         type_in       = '0;
         rpcver_ok_in  = 1'b0;
         prog_in       = '0;
         vers_in       = '0;
         proc_in       = '0;
         rstat_in      = '0;
         astat_in      = '0;
         len_in        = '0;
      end else if (frag_end) begin
         mark_count_in = '0;
         mark_shift_in = '0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (proc_go && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_prog_ff <= WatchedProgramReset;
         watched_vers_ff <= WatchedVersionReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrWatchedProgram: watched_prog_ff <= csr_data;
            CsrWatchedVersion: watched_vers_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (proc_go && emit) begin
         out_ff <= summary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mark_shift_ff <= '0;
         mark_count_ff <= '0;
         frag_rem_ff   <= '0;
         last_ff       <= 1'b0;
         step_ff       <= StXid;
         acc_ff        <= '0;
         word_count_ff <= '0;
         skip_ff       <= '0;
         xid_ff        <= '0;
         type_ff       <= '0;
         rpcver_ok_ff  <= 1'b0;
         prog_ff       <= '0;
         vers_ff       <= '0;
         proc_ff       <= '0;
         rstat_ff      <= '0;
         astat_ff      <= '0;
         len_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc_go) begin
            mark_shift_ff <= mark_shift_in;
            mark_count_ff <= mark_count_in;
            frag_rem_ff   <= frag_rem_in;
            last_ff       <= last_in;
            step_ff       <= step_in;
            acc_ff        <= acc_in;
            word_count_ff <= word_count_in;
            skip_ff       <= skip_in;
            xid_ff        <= xid_in;
            type_ff       <= type_in;
            rpcver_ok_ff  <= rpcver_ok_in;
            prog_ff       <= prog_in;
            vers_ff       <= vers_in;
            proc_ff       <= proc_in;
            rstat_ff      <= rstat_in;
            astat_ff      <= astat_in;
            len_ff        <= len_in;
         end
      end
   end

endmodule
